>>> rtl/assert_macros.svh
// assertion macros for the rtl files; only the core top file includes them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define QES_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define QES_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/qes_pkg.sv
// shared constants, tables and types for the quaternion to euler sector core
package qes_pkg;

   localparam int SECTOR_COUNT = 18;
   localparam int CORDIC_STEPS = 16;
   localparam int TABLE_LEN    = 24;
   localparam int CORDIC_USED  = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam int IN_W   = 16;
   localparam int PROD_W = 32;
   localparam int NUM_W  = 34;
   localparam int AW     = 32;
   localparam int XW     = 38;
   localparam int ZW     = 36;
   localparam int RES_W  = 62;
   localparam int ISQ_STEPS = 31;
   localparam int OFF_W  = 34;
   localparam int QB     = $clog2(SECTOR_COUNT + 1);
   localparam int T_W    = OFF_W + QB;
   localparam int DIV_W  = T_W + 1;
   localparam int SECT_W = 5;

   // angle lanes of the back pipeline
   localparam int LANES      = 3;
   localparam int LANE_ROLL  = 0;
   localparam int LANE_PITCH = 1;
   localparam int LANE_YAW   = 2;

   // back stages: input, square root steps, cordic setup and steps, scaling, sector compare
   localparam int NST = ISQ_STEPS + CORDIC_USED + 4;

   localparam logic signed [NUM_W-1:0] ONE_Q30     = NUM_W'(64'sd1073741824);
   localparam logic signed [ZW-1:0]    PI_Q30      = ZW'(64'sd3373259426);
   localparam logic signed [ZW-1:0]    HALF_PI_Q30 = ZW'(64'sd1686629713);
   localparam logic [DIV_W-1:0]        TWO_PI_DIV  = DIV_W'(64'd6746518852);
   localparam logic [DIV_W-1:0]        PI_DIV      = DIV_W'(64'd3373259426);
   localparam logic [RES_W-1:0]        SQ_TOP      = RES_W'(64'd1) << 60;

   // atan(2^-i) in q30 radians
   localparam logic [31:0] ATAN_TABLE [TABLE_LEN] = '{
      32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
      32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
      32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
      32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
   };

   typedef struct packed {
      logic signed [NUM_W-1:0] roll_num;
      logic signed [NUM_W-1:0] roll_den;
      logic signed [NUM_W-1:0] yaw_num;
      logic signed [NUM_W-1:0] yaw_den;
      logic signed [AW-1:0]    pitch_arg;
      logic                    pitch_pos_sat;
      logic                    pitch_neg_sat;
   } qes_entry_type;

   typedef struct packed {
      logic              empty;
      logic              full;
      logic [QCNT_W-1:0] count;
   } qes_queue_stat_type;

endpackage

>>> rtl/qes_channels_if.sv
// request and response channel interfaces
interface qes_req_if;
   import qes_pkg::*;
   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] quat_w;
   logic signed [IN_W-1:0] quat_x;
   logic signed [IN_W-1:0] quat_y;
   logic signed [IN_W-1:0] quat_z;
   modport source (output valid, quat_w, quat_x, quat_y, quat_z, input ready);
   modport sink (input valid, quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface qes_rsp_if;
   import qes_pkg::*;
   logic              valid;
   logic              ready;
   logic [SECT_W-1:0] roll_sector;
   logic [SECT_W-1:0] pitch_sector;
   logic [SECT_W-1:0] yaw_sector;
   modport source (output valid, roll_sector, pitch_sector, yaw_sector, input ready);
   modport sink (input valid, roll_sector, pitch_sector, yaw_sector, output ready);
endinterface

>>> rtl/quaternion_to_euler_sector_core.sv
// throughput: one item per cycle while results are taken; the square root, cordic and sector compare are pipelined
// the whole back pipeline holds when a finished result is not taken
// reset (synchronous, active high) empties the queue and clears all valid bits
`include "assert_macros.svh"
module quaternion_to_euler_sector_core (
   input  logic      clock,
   input  logic      reset,
   qes_req_if.sink   req_bus,
   qes_rsp_if.source rsp_bus
);
   import qes_pkg::*;

   qes_entry_type      push_data;
   qes_entry_type      head;
   qes_queue_stat_type q_stat;
   logic               q_push;
   logic               q_pop;

   qes_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .q_stat    (q_stat),
      .push      (q_push),
      .push_data (push_data)
   );

   qes_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_data),
      .pop       (q_pop),
      .head      (head),
      .stat      (q_stat)
   );

   qes_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_data  (head),
      .q_empty (q_stat.empty),
      .q_pop   (q_pop),
      .rsp_bus (rsp_bus)
   );

   `QES_ASSERT_IMP(a_no_overflow, clock, reset, q_push, !q_stat.full || q_pop, "queue overflow")
   `QES_ASSERT_NXT(a_accept_push, clock, reset, req_bus.valid && req_bus.ready, q_push, "item lost")

endmodule

>>> rtl/qes_front.sv
// front end: accepts quaternions, forms products and atan2 arguments
module qes_front (
   input  logic                        clock,
   input  logic                        reset,
   qes_req_if.sink                     req_bus,
   input  qes_pkg::qes_queue_stat_type q_stat,
   output logic                        push,
   output qes_pkg::qes_entry_type      push_data
);
   import qes_pkg::*;

   logic                     a_valid_ff, a_valid_in;
   logic signed [PROD_W-1:0] wx_ff, yz_ff, xx_ff, yy_ff, zz_ff, wz_ff, xy_ff, wy_ff, zx_ff;
   logic [QCNT_W:0]          used;
   logic                     accept;
   logic signed [NUM_W-1:0]  a_raw;

   // queue slots plus the item held in the product register
   assign used = {1'b0, q_stat.count} + (QCNT_W + 1)'(a_valid_ff);
   assign req_bus.ready = (used < (QCNT_W + 1)'(QDEPTH));
   assign accept = req_bus.valid && req_bus.ready;
   assign a_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wx_ff <= PROD_W'(req_bus.quat_w) * PROD_W'(req_bus.quat_x);
         yz_ff <= PROD_W'(req_bus.quat_y) * PROD_W'(req_bus.quat_z);
         xx_ff <= PROD_W'(req_bus.quat_x) * PROD_W'(req_bus.quat_x);
         yy_ff <= PROD_W'(req_bus.quat_y) * PROD_W'(req_bus.quat_y);
         zz_ff <= PROD_W'(req_bus.quat_z) * PROD_W'(req_bus.quat_z);
         wz_ff <= PROD_W'(req_bus.quat_w) * PROD_W'(req_bus.quat_z);
         xy_ff <= PROD_W'(req_bus.quat_x) * PROD_W'(req_bus.quat_y);
         wy_ff <= PROD_W'(req_bus.quat_w) * PROD_W'(req_bus.quat_y);
         zx_ff <= PROD_W'(req_bus.quat_z) * PROD_W'(req_bus.quat_x);
      end
   end

   always_comb begin
      push_data.roll_num = (NUM_W'(wx_ff) + NUM_W'(yz_ff)) <<< 1;
      push_data.roll_den = ONE_Q30 - ((NUM_W'(xx_ff) + NUM_W'(yy_ff)) <<< 1);
      push_data.yaw_num  = (NUM_W'(wz_ff) + NUM_W'(xy_ff)) <<< 1;
      push_data.yaw_den  = ONE_Q30 - ((NUM_W'(yy_ff) + NUM_W'(zz_ff)) <<< 1);
      a_raw = (NUM_W'(wy_ff) - NUM_W'(zx_ff)) <<< 1;
      push_data.pitch_pos_sat = 1'b0;
      push_data.pitch_neg_sat = 1'b0;
      if (a_raw >= ONE_Q30) begin
         push_data.pitch_arg     = ONE_Q30[AW-1:0];
         push_data.pitch_pos_sat = 1'b1;
      end else if (a_raw <= -ONE_Q30) begin
         push_data.pitch_arg     = AW'(-ONE_Q30);
         push_data.pitch_neg_sat = 1'b1;
      end else begin
         push_data.pitch_arg = a_raw[AW-1:0];
      end
   end

   assign push = a_valid_ff;

endmodule

>>> rtl/qes_queue.sv
// short queue between the front end and the angle pipeline
module qes_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  qes_pkg::qes_entry_type      push_data,
   input  logic                        pop,
   output qes_pkg::qes_entry_type      head,
   output qes_pkg::qes_queue_stat_type stat
);
   import qes_pkg::*;

   qes_entry_type     mem_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head       = mem_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == QCNT_W'(QDEPTH));
   assign stat.count = count_ff;

endmodule

>>> rtl/qes_back.sv
// back end: square root, three cordic lanes and sector compare in one pipeline
module qes_back (
   input  logic                   clock,
   input  logic                   reset,
   input  qes_pkg::qes_entry_type q_data,
   input  logic                   q_empty,
   output logic                   q_pop,
   qes_rsp_if.source              rsp_bus
);
   import qes_pkg::*;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
      logic signed [ZW-1:0] z;
      logic                 spec;
      logic signed [ZW-1:0] spec_ang;
   } cstate_type;

   typedef struct packed {
      logic [RES_W-1:0] v;
      logic [RES_W-1:0] res;
   } isq_type;

   logic               vld_ff [NST];
   logic               adv;
   qes_entry_type      ent_ff [ISQ_STEPS+1];
   isq_type            isq_ff [ISQ_STEPS+1];
   cstate_type         cst_ff [LANES][CORDIC_USED+1];
   logic               pos_ff [CORDIC_USED+1];
   logic               neg_ff [CORDIC_USED+1];
   logic [DIV_W-1:0]   scl_ff [LANES];
   logic [QB-1:0]      quo_ff [LANES];
   logic signed [2*AW-1:0] a_sq;

   function automatic isq_type isq_step(isq_type s, int k);
      logic [RES_W-1:0] bit_val;
      logic [RES_W-1:0] trial;
      isq_type          r;
      bit_val = RES_W'(1) << (2 * (ISQ_STEPS - 1 - k));
      trial   = s.res + bit_val;
      if (s.v >= trial) begin
         r.v   = s.v - trial;
         r.res = (s.res >> 1) + bit_val;
      end else begin
         r.v   = s.v;
         r.res = s.res >> 1;
      end
      return r;
   endfunction

   function automatic cstate_type cordic_init(logic signed [NUM_W-1:0] num,
                                              logic signed [NUM_W-1:0] den);
      cstate_type c;
      c.x = XW'(den);
      c.y = XW'(num);
      c.z = '0;
      c.spec = 1'b0;
      c.spec_ang = '0;
      if (num == '0) begin
         c.spec = 1'b1;
         c.spec_ang = (den < 0) ? PI_Q30 : '0;
      end else if (den == '0) begin
         c.spec = 1'b1;
         c.spec_ang = (num > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
      end else if (den < 0) begin
         c.x = -XW'(den);
         c.y = -XW'(num);
         c.z = (num > 0) ? PI_Q30 : -PI_Q30;
      end
      return c;
   endfunction

   function automatic cstate_type cordic_step(cstate_type c, int i);
      cstate_type r;
      logic signed [ZW-1:0] ang;
      r   = c;
      ang = ZW'(ATAN_TABLE[i]);
      if (c.y > 0) begin
         r.x = c.x + (c.y >>> i);
         r.y = c.y - (c.x >>> i);
         r.z = c.z + ang;
      end else begin
         r.x = c.x - (c.y >>> i);
         r.y = c.y + (c.x >>> i);
         r.z = c.z - ang;
      end
      return r;
   endfunction

   function automatic logic signed [ZW-1:0] clampz(logic signed [ZW-1:0] v,
                                                   logic signed [ZW-1:0] lim);
      logic signed [ZW-1:0] r;
      r = v;
      if (v > lim) begin
         r = lim;
      end else if (v < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   // scaled offset angle: (angle + offset) * SECTOR_COUNT
   function automatic logic [DIV_W-1:0] lane_scaled(cstate_type c, int lane, logic pos,
                                                    logic neg);
      logic signed [ZW-1:0] ang;
      logic signed [ZW-1:0] off;
      logic [OFF_W-1:0]     off_u;
      ang = c.spec ? c.spec_ang : clampz(c.z, PI_Q30 - 1);
      if (lane == LANE_PITCH) begin
         if (pos) begin
            ang = HALF_PI_Q30;
         end else if (neg) begin
            ang = -HALF_PI_Q30;
         end else begin
            ang = clampz(ang, HALF_PI_Q30 - 1);
         end
         off = ang + HALF_PI_Q30;
      end else begin
         off = ang + PI_Q30;
      end
      off_u = off[OFF_W-1:0];
      return DIV_W'(T_W'(off_u) * T_W'(SECTOR_COUNT));
   endfunction

   // floor of v / span: count of sector boundaries at or below v
   function automatic logic [QB-1:0] sector_of(logic [DIV_W-1:0] v, logic [DIV_W-1:0] span);
      logic [QB-1:0] q;
      q = '0;
      for (int k = 1; k <= SECTOR_COUNT; k++) begin
         if (v >= DIV_W'(k) * span) begin
            q = q + 1'b1;
         end
      end
      return q;
   endfunction

   assign adv   = !vld_ff[NST-1] || rsp_bus.ready;
   assign q_pop = !q_empty && adv;
   assign a_sq  = (2 * AW)'(q_data.pitch_arg) * (2 * AW)'(q_data.pitch_arg);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NST; s++) begin
            vld_ff[s] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= q_pop;
         for (int s = 1; s < NST; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         // square and remainder under one
         ent_ff[0]     <= q_data;
         isq_ff[0].v   <= SQ_TOP - RES_W'(a_sq[60:0]);
         isq_ff[0].res <= '0;
         for (int k = 0; k < ISQ_STEPS; k++) begin
            ent_ff[k+1] <= ent_ff[k];
            isq_ff[k+1] <= isq_step(isq_ff[k], k);
         end
         // lane setup
         cst_ff[LANE_ROLL][0] <= cordic_init(ent_ff[ISQ_STEPS].roll_num,
                                             ent_ff[ISQ_STEPS].roll_den);
         cst_ff[LANE_YAW][0] <= cordic_init(ent_ff[ISQ_STEPS].yaw_num,
                                            ent_ff[ISQ_STEPS].yaw_den);
         cst_ff[LANE_PITCH][0] <= cordic_init(NUM_W'(ent_ff[ISQ_STEPS].pitch_arg),
                                              NUM_W'(isq_ff[ISQ_STEPS].res[NUM_W-2:0]));
         pos_ff[0] <= ent_ff[ISQ_STEPS].pitch_pos_sat;
         neg_ff[0] <= ent_ff[ISQ_STEPS].pitch_neg_sat;
         for (int j = 0; j < CORDIC_USED; j++) begin
            for (int l = 0; l < LANES; l++) begin
               cst_ff[l][j+1] <= cordic_step(cst_ff[l][j], j);
            end
            pos_ff[j+1] <= pos_ff[j];
            neg_ff[j+1] <= neg_ff[j];
         end
         // scale, then compare against the constant sector boundaries
         for (int l = 0; l < LANES; l++) begin
            scl_ff[l] <= lane_scaled(cst_ff[l][CORDIC_USED], l,
                                     pos_ff[CORDIC_USED], neg_ff[CORDIC_USED]);
            quo_ff[l] <= sector_of(scl_ff[l], (l == LANE_PITCH) ? PI_DIV : TWO_PI_DIV);
         end
      end
   end

   assign rsp_bus.valid        = vld_ff[NST-1];
   assign rsp_bus.roll_sector  = SECT_W'(quo_ff[LANE_ROLL]);
   assign rsp_bus.pitch_sector = SECT_W'(quo_ff[LANE_PITCH]);
   assign rsp_bus.yaw_sector   = SECT_W'(quo_ff[LANE_YAW]);

endmodule
